FILE: src/dtf_pkg.sv
package dtf_pkg;

    // Sector geometry
    localparam int DATA_WORDS        = 256;
    localparam int TRAILER_WORDS     = 11;
    localparam int GROUPS_PER_SECTOR = DATA_WORDS / 4;
    localparam int INPUTS_PER_SECTOR = GROUPS_PER_SECTOR * 3;
    localparam int RECORD_WORDS      = DATA_WORDS + 1 + TRAILER_WORDS;
    localparam int SECTOR_RESULTS    = 3 + TRAILER_WORDS;

    // Field and counter widths
    localparam int WORD_W   = 32;
    localparam int TRACK_W  = 15;
    localparam int SEC_W    = 2;
    localparam int POS_W    = 9;
    localparam int SEG_W    = 18;
    localparam int COUNT_W  = $clog2(INPUTS_PER_SECTOR);
    localparam int GROUP_W  = $clog2(GROUPS_PER_SECTOR);
    localparam int STEP_W   = $clog2(SECTOR_RESULTS);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Drum word constants
    localparam logic [WORD_W-1:0] INV_MASK  = 32'h6666_6600;
    localparam logic [WORD_W-1:0] ADDR_FLAG = 32'h8000_0000;

    typedef struct packed {
        logic [WORD_W-1:0]  file_word;
        logic [TRACK_W-1:0] track;
        logic [SEC_W-1:0]   sector;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] track_word;
        logic [POS_W-1:0]  word_position;
        logic              seek_fault;
        logic              last_of_run;
    } t_out_item;

    // How many results one job expands into
    typedef enum logic [1:0] {
        K_ONE    = 2'd0,
        K_TWO    = 2'd1,
        K_SECTOR = 2'd2
    } t_kind;

    // One classified input, handed from front to back
    typedef struct packed {
        logic [WORD_W-1:0]  d0;
        logic [WORD_W-1:0]  d1;
        logic [WORD_W-1:0]  parity;
        logic [TRACK_W-1:0] track;
        logic [SEC_W-1:0]   next_sec;
        logic [POS_W-1:0]   pos;
        logic               fault;
        t_kind              kind;
    } t_job;

    // Sector address word: flag bit plus (track*4 + sector) in bits 24..8
    function automatic logic [WORD_W-1:0] addr_word(
        input logic [TRACK_W-1:0] track,
        input logic [SEC_W-1:0]   sec
    );
        addr_word = ADDR_FLAG
                  | {{(WORD_W - TRACK_W - SEC_W - 8){1'b0}}, track, sec, 8'h00};
    endfunction

endpackage

FILE: src/drum_track_formatter_core.sv
// Channel   Dir  Handshake        Payload
// input     in   push / full      i_in_item  (file_word, track, sector)
// result    out  empty / pop      o_out_item (track_word, word_position, seek_fault,
//                                             last_of_run)
// config    in   i_cfg_we         i_cfg_data (segment_count)
//
// An input is classified in the cycle it is taken and queued; one result leaves per cycle
// while pop is high. Results per input: 1, 1, 2, and 14 on the last input of a sector;
// the single output register sets the sustained rate: 268 results per 192-input sector
// (about 1.4 per input). The first result passes the job queue, then the output register.
// Reset is synchronous, active low; it clears segment_count and all sector state.
// A held result stalls the back; full rises once the four-entry job queue fills behind it.
module drum_track_formatter_core
    import dtf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [SEG_W-1:0] i_cfg_data,
    input  logic             push,
    input  t_in_item         i_in_item,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output t_out_item        o_out_item
);

    t_job front_job;
    t_job head_job;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign accept = push && !full;

    dtf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .o_job      (front_job)
    );

    dtf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    dtf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

`ifndef ASSERT_OFF
    // a faulted result never carries data
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.seek_fault) |-> (o_out_item.track_word == '0))
        else $error("faulted result carries nonzero word");

    // positions stay inside the sector record
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_item.word_position < POS_W'(RECORD_WORDS)))
        else $error("word position beyond sector record");

    // the parity word is always followed by address words of the same input
    a_parity_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.word_position == POS_W'(DATA_WORDS))
            |-> !o_out_item.last_of_run)
        else $error("parity word marked last");

    // the back end only drains the queue when it holds a job
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job queue popped while empty");
`endif

endmodule

FILE: src/dtf_front.sv
module dtf_front
    import dtf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [SEG_W-1:0] i_cfg_data,
    input  logic             i_accept,
    input  t_in_item         i_item,
    output t_job             o_job
);

    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } t_phase;

    logic [SEG_W-1:0]   r_seg_count;
    logic [WORD_W-1:0]  r_held;
    logic [WORD_W-1:0]  r_parity;
    logic [COUNT_W-1:0] r_count;
    logic [GROUP_W-1:0] r_group;
    t_phase             r_phase;

    logic [WORD_W-1:0]  n_held;
    logic [WORD_W-1:0]  n_parity;
    logic [COUNT_W-1:0] n_count;
    logic [GROUP_W-1:0] n_group;
    t_phase             n_phase;

    logic [WORD_W-1:0]  w;
    logic [WORD_W-1:0]  seed;
    logic [WORD_W-1:0]  d0;
    logic [WORD_W-1:0]  d1;
    logic [SEG_W-1:0]   need;
    logic [POS_W-1:0]   offset;
    logic               end_sector;

    assign w          = i_item.file_word;
    assign end_sector = (r_count == COUNT_W'(INPUTS_PER_SECTOR - 1));
    assign seed       = (r_count == '0) ? addr_word(i_item.track, i_item.sector) : r_parity;
    // a track occupies segments track*4 .. track*4+3
    assign need       = {1'b0, i_item.track, 2'b00} + SEG_W'(4);

    // repack and classify
    always_comb begin
        d0     = '0;
        d1     = '0;
        offset = '0;
        n_held = r_held;
        unique case (r_phase)
            PH_0: begin
                d0      = {w[23:0], 8'h00} ^ INV_MASK;
                n_held  = w;
                n_phase = PH_1;
            end
            PH_1: begin
                d0      = {w[15:0], r_held[31:24], 8'h00} ^ INV_MASK;
                n_held  = w;
                offset  = POS_W'(1);
                n_phase = PH_2;
            end
            PH_2: begin
                d0      = {w[7:0], r_held[31:16], 8'h00} ^ INV_MASK;
                d1      = {w[31:8], 8'h00} ^ INV_MASK;
                offset  = POS_W'(2);
                n_phase = PH_0;
            end
            default: begin
                n_phase = PH_0;
            end
        endcase
        n_parity = seed ^ d0 ^ d1;
        if (end_sector) begin
            n_count = '0;
            n_group = '0;
            n_phase = PH_0;
        end else begin
            n_count = r_count + COUNT_W'(1);
            n_group = (r_phase == PH_2) ? r_group + GROUP_W'(1) : r_group;
        end
    end

    // job handed to the queue
    always_comb begin
        o_job.d0       = d0;
        o_job.d1       = d1;
        o_job.parity   = n_parity;
        o_job.track    = i_item.track;
        o_job.next_sec = i_item.sector + SEC_W'(1);
        o_job.pos      = POS_W'({r_group, 2'b00}) + offset;
        o_job.fault    = (need > r_seg_count);
        if (r_phase != PH_2) begin
            o_job.kind = K_ONE;
        end else if (end_sector) begin
            o_job.kind = K_SECTOR;
        end else begin
            o_job.kind = K_TWO;
        end
    end

    // state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= '0;
            r_held      <= '0;
            r_parity    <= '0;
            r_count     <= '0;
            r_group     <= '0;
            r_phase     <= PH_0;
        end else begin
            if (i_cfg_we) begin
                r_seg_count <= i_cfg_data;
            end
            if (i_accept) begin
                r_held   <= n_held;
                r_parity <= n_parity;
                r_count  <= n_count;
                r_group  <= n_group;
                r_phase  <= n_phase;
            end
        end
    end

endmodule

FILE: src/dtf_queue.sv
module dtf_queue
    import dtf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

FILE: src/dtf_back.sv
module dtf_back
    import dtf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_job      i_job,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    t_out_item         r_item;

    logic              load;
    logic              last_step;
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0]  pos;
    logic              last;

    assign load = !r_valid || i_pop;

    // pick the word for the current step of the head job
    always_comb begin
        last_step = 1'b0;
        last      = 1'b0;
        case (r_step)
            STEP_W'(0): begin
                word      = i_job.d0;
                pos       = i_job.pos;
                last_step = (i_job.kind == K_ONE);
                last      = last_step;
            end
            STEP_W'(1): begin
                word      = i_job.d1;
                pos       = i_job.pos + POS_W'(1);
                last_step = (i_job.kind == K_TWO);
                last      = last_step;
            end
            STEP_W'(2): begin
                word = i_job.parity;
                pos  = POS_W'(DATA_WORDS);
            end
            default: begin
                word      = addr_word(i_job.track, i_job.next_sec);
                pos       = POS_W'(DATA_WORDS - 2) + POS_W'(r_step);
                last_step = (r_step == STEP_W'(SECTOR_RESULTS - 1));
                last      = last_step;
            end
        endcase
    end

    assign o_q_pop = load && !i_q_empty && last_step;

    // output register
    always_ff @(posedge i_clk) begin
        if (load && !i_q_empty) begin
            r_item.track_word    <= i_job.fault ? '0 : word;
            r_item.word_position <= pos;
            r_item.seek_fault    <= i_job.fault;
            r_item.last_of_run   <= last;
        end
    end

    // step counter and valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            if (!i_q_empty) begin
                r_step <= last_step ? '0 : r_step + STEP_W'(1);
            end
        end
    end

    assign o_empty = !r_valid;
    assign o_item  = r_item;

endmodule

FILE: verif/drum_format_checker.sv
`timescale 1ns / 1ps

// Watches the input, result and config channels of the drum track formatter,
// predicts the drum words for every accepted item and compares them in order.
module drum_format_checker
    import dtf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [SEG_W-1:0] i_cfg_data,
    input  logic             i_push,
    input  logic             i_full,
    input  t_in_item         i_in_item,
    input  logic             i_pop,
    input  logic             i_empty,
    input  t_out_item        i_out_item,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_faulted,
    output int               o_trailers
);

    // Position of a file word inside its group of three
    typedef enum logic [1:0] {
        LEAD   = 2'd0,
        MIDDLE = 2'd1,
        CLOSE  = 2'd2
    } t_group_pos;

    // Predicted formatter state
    logic [SEG_W-1:0]  seg_count;
    logic [WORD_W-1:0] held_word;
    logic [WORD_W-1:0] parity;
    t_group_pos        group_pos;
    int                fed_count;

    // Drum words still owed by the block, oldest first
    t_out_item expected_words[$];
    t_out_item want;
    int        fails, checked, faulted, trailers;

    // Sector address word: flag on top, (track*4 + sector) in bits 24..8
    function automatic logic [WORD_W-1:0] sector_address(logic [TRACK_W-1:0] trk,
                                                         logic [SEC_W-1:0] sec);
        return {1'b1, 6'b0, trk, sec, 8'h00};
    endfunction

    function automatic void queue_result(logic [WORD_W-1:0] word, int pos,
                                         logic fault, logic last);
        t_out_item r;
        r.track_word    = fault ? '0 : word;
        r.word_position = POS_W'(pos);
        r.seek_fault    = fault;
        r.last_of_run   = last;
        expected_words.push_back(r);
    endfunction

    // Repack one file word into drum words, with trailer at the end of a sector
    function automatic void format_item(t_in_item it);
        logic [WORD_W-1:0] w, d0, d1, next_addr;
        int unsigned       need;
        logic              fault, end_sector;
        int                base;
        w          = it.file_word;
        need       = 32'(it.track) * 4 + 4;
        fault      = need > 32'(seg_count);
        end_sector = fed_count >= INPUTS_PER_SECTOR - 1;
        base       = (fed_count / 3) * 4;
        if (fed_count == 0)
            parity = sector_address(it.track, it.sector);
        case (group_pos)
            LEAD: begin
                d0 = (w << 8) ^ INV_MASK;
                parity = parity ^ d0;
                held_word = w;
                queue_result(d0, base, fault, 1'b1);
                group_pos = MIDDLE;
            end
            MIDDLE: begin
                d0 = (((held_word & 32'hFF00_0000) >> 16) | (w << 16)) ^ INV_MASK;
                parity = parity ^ d0;
                held_word = w;
                queue_result(d0, base + 1, fault, 1'b1);
                group_pos = CLOSE;
            end
            default: begin
                d0 = (((held_word & 32'hFFFF_0000) >> 8) | (w << 24)) ^ INV_MASK;
                d1 = (w & 32'hFFFF_FF00) ^ INV_MASK;
                parity = parity ^ d0 ^ d1;
                queue_result(d0, base + 2, fault, 1'b0);
                queue_result(d1, base + 3, fault, !end_sector);
                group_pos = LEAD;
                if (end_sector) begin
                    // trailer: parity, then address words of the next sector
                    next_addr = sector_address(it.track, it.sector + 2'd1);
                    queue_result(parity, DATA_WORDS, fault, 1'b0);
                    for (int i = 0; i < TRAILER_WORDS; i++)
                        queue_result(next_addr, DATA_WORDS + 1 + i, fault,
                                     i == TRAILER_WORDS - 1);
                end
            end
        endcase
        if (end_sector) begin
            fed_count = 0;
            group_pos = LEAD;
        end else begin
            fed_count++;
        end
    endfunction

    initial begin
        fails    = 0;
        checked  = 0;
        faulted  = 0;
        trailers = 0;
    end

    // Compare the item leaving first, then predict the item arriving
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_count = '0;
            held_word = '0;
            parity    = '0;
            group_pos = LEAD;
            fed_count = 0;
            expected_words.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_words.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected item word %h pos %0d fault %b last %b", $time,
                             i_out_item.track_word, i_out_item.word_position,
                             i_out_item.seek_fault, i_out_item.last_of_run);
                end else begin
                    want = expected_words.pop_front();
                    checked++;
                    if (want.seek_fault)
                        faulted++;
                    if (want.word_position == POS_W'(DATA_WORDS))
                        trailers++;
                    if (i_out_item.track_word !== want.track_word
                        || i_out_item.word_position !== want.word_position
                        || i_out_item.seek_fault !== want.seek_fault
                        || i_out_item.last_of_run !== want.last_of_run) begin
                        fails++;
                        $display("%0t: mismatch expected word %h pos %0d fault %b last %b",
                                 $time, want.track_word, want.word_position,
                                 want.seek_fault, want.last_of_run);
                        $display("%0t:          actual   word %h pos %0d fault %b last %b",
                                 $time, i_out_item.track_word, i_out_item.word_position,
                                 i_out_item.seek_fault, i_out_item.last_of_run);
                    end
                end
            end
            // an item taken at the same edge as a config write sees the old count
            if (i_push && !i_full)
                format_item(i_in_item);
            if (i_cfg_we)
                seg_count = i_cfg_data;
        end
        o_fail_count <= fails;
        o_pending    <= expected_words.size();
        o_checked    <= checked;
        o_faulted    <= faulted;
        o_trailers   <= trailers;
    end

endmodule

FILE: verif/tb_drum_track_formatter_core.sv
`timescale 1ns / 1ps

module tb_drum_track_formatter_core;
    import dtf_pkg::*;

    localparam int SEG_MAX     = 131072;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 83;
    localparam int HOLD_CYCLES = 80;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [SEG_W-1:0] i_cfg_data;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    t_in_item         i_in_item;
    t_out_item        o_out_item;

    int fail_count, pending, checked, faulted, trailers;
    int items_sent;
    int stall_cycles;
    bit hold_request;
    bit hold_done;
    int send_calm, take_calm;
    logic [TRACK_W-1:0] run_track;
    logic [SEC_W-1:0]   run_sector;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    drum_track_formatter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .i_in_item  (i_in_item),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .o_out_item (o_out_item)
    );

    drum_format_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_in_item    (i_in_item),
        .i_pop        (pop),
        .i_empty      (empty),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_faulted    (faulted),
        .o_trailers   (trailers)
    );

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 6) begin
            calm_left = $urandom_range(16, 48);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Track near the image boundary, beyond it, below it or anywhere
    function automatic logic [TRACK_W-1:0] pick_track(int seg);
        int limit;
        limit = seg / 4;
        case ($urandom_range(0, 3))
            0: return TRACK_W'($urandom_range(0, 32767));
            1: return TRACK_W'((limit > 0) ? limit - 1 : 0);
            2: return TRACK_W'((limit <= 32767) ? limit : $urandom_range(0, 32767));
            default: return TRACK_W'((limit > 0) ? $urandom_range(0, limit - 1) : 0);
        endcase
    endfunction

    task automatic send_item(input logic [WORD_W-1:0] w, input logic [TRACK_W-1:0] trk,
                             input logic [SEC_W-1:0] sec);
        int gap;
        push                <= 1'b1;
        i_in_item.file_word <= w;
        i_in_item.track     <= trk;
        i_in_item.sector    <= sec;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        items_sent++;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every owed item has come back
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_segments(input int seg);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= SEG_W'(seg);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly steady track/sector runs; a few stray items as noise
    task automatic run_phase(input int seg, input int count, input bit ask_hold);
        int pos;
        bit stray;
        run_track = pick_track(seg);
        for (int k = 0; k < count; k++) begin
            if (ask_hold && k == 20)
                hold_request = 1'b1;
            pos   = items_sent % INPUTS_PER_SECTOR;
            stray = ($urandom_range(0, 9) == 0) && (pos != INPUTS_PER_SECTOR - 1);
            if (stray)
                send_item($urandom, TRACK_W'($urandom_range(0, 32767)),
                          SEC_W'($urandom_range(0, 3)));
            else
                send_item($urandom, run_track, run_sector);
            if (items_sent % INPUTS_PER_SECTOR == 0) begin
                run_sector = run_sector + 2'd1;
                if ($urandom_range(0, 3) == 0)
                    run_track = pick_track(seg);
            end
        end
    endtask

    // Watchdog on cycles with no item moving either way
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Receiver: random gaps, one long hold-off while the sender keeps pushing
    initial begin
        int gap;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty)
                @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = pick_gap(take_calm);
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        items_sent   = 0;
        stall_cycles = 0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        send_calm    = 0;
        take_calm    = 0;
        run_sector   = 2'd2;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        push         <= 1'b0;
        pop          <= 1'b0;
        i_in_item    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Segment count still zero from reset: every track faults
        send_item(32'h0000_0000, 15'd0, 2'd0);
        send_item(32'hFFFF_FFFF, 15'd32767, 2'd3);
        send_item(32'h0123_4567, 15'd0, 2'd1);
        settle();

        // Largest image: the last track just fits
        set_segments(SEG_MAX);
        send_item(32'hFFFF_FFFF, 15'd32767, 2'd0);
        send_item(32'h0000_0000, 15'd32767, 2'd1);
        send_item(32'hFFFF_FFFF, 15'd0, 2'd2);
        send_item(32'h8000_0001, 15'd12345, 2'd3);
        send_item(32'h7FFF_FFFE, 15'd32767, 2'd0);
        send_item(32'hA5A5_A5A5, 15'd1, 2'd1);
        settle();

        // 400 segments: track 99 fits, track 100 does not
        set_segments(400);
        send_item(32'hDEAD_BEEF, 15'd99, 2'd2);
        send_item(32'hCAFE_F00D, 15'd100, 2'd2);
        send_item(32'hFF00_FF00, 15'd0, 2'd3);
        send_item(32'h00FF_00FF, 15'd32767, 2'd0);
        send_item(32'h5A5A_5A5A, 15'd99, 2'd1);
        send_item(32'h1234_5678, 15'd101, 2'd3);
        settle();

        // Random phases across several image sizes
        set_segments(0);
        run_phase(0, PHASE_ITEMS, 1'b0);
        settle();
        set_segments($urandom_range(0, SEG_MAX));
        run_phase(int'(i_cfg_data), PHASE_ITEMS, 1'b0);
        settle();
        set_segments(SEG_MAX);
        run_phase(SEG_MAX, PHASE_ITEMS, 1'b1);
        settle();
        set_segments($urandom_range(0, 64));
        run_phase(int'(i_cfg_data), PHASE_ITEMS, 1'b0);
        settle();
        set_segments($urandom_range(0, SEG_MAX));
        run_phase(int'(i_cfg_data), PHASE_ITEMS, 1'b0);
        settle();
        repeat (10) @(posedge i_clk);

        $display("covered %0d items, %0d results checked across %0d image sizes",
                 items_sent, checked, 8);
        $display("%0d results under seek fault, %0d sector trailers, long receiver hold %0s",
                 faulted, trailers, hold_done ? "done" : "missed");
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
